// ===== sv/tvpr_pkg.sv =====
package tvpr_pkg;

    // Packet and frame geometry of the video link.
    localparam int PIXELS_PER_PACKET   = 80;
    localparam int HEADER_WORDS        = 2;
    localparam int PACKETS_PER_SEGMENT = 60;
    localparam int SEGMENTS_PER_FRAME  = 4;
    localparam int BUFFER_COUNT        = 3;
    localparam int SEGMENT_MARK_PACKET = 20;

    localparam int PACKET_WORDS   = HEADER_WORDS + PIXELS_PER_PACKET;
    localparam int SEGMENT_PIXELS = PACKETS_PER_SEGMENT * PIXELS_PER_PACKET;
    localparam int FRAME_PIXELS   = SEGMENTS_PER_FRAME * SEGMENT_PIXELS;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int WORD_W   = 16;
    localparam int BUF_W    = 2;
    localparam int OFS_W    = 15;
    localparam int SUM_W    = 18;
    localparam int INDEX_W  = $clog2(PACKET_WORDS);
    localparam int PKT_W    = $clog2(PACKETS_PER_SEGMENT);
    localparam int SEG_W    = 2;
    localparam int PID_W    = 12;
    localparam int SEGF_W   = 3;

    // Header word fields.
    localparam logic [WORD_W-1:0] DONT_CARE_MASK  = 16'h0F00;
    localparam logic [WORD_W-1:0] PACKET_NUM_MASK = 16'h0FFF;
    localparam logic [SEGF_W-1:0] SEG_FIELD_MASK  = 3'h7;
    localparam int                SEG_FIELD_LSB   = 12;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WORD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESYNC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    typedef logic [BUF_W-1:0] t_buf;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] link_word;
    } t_in_item;

    typedef struct packed {
        logic              pixel_write;
        t_buf              pixel_buffer;
        logic [OFS_W-1:0]  pixel_offset;
        logic [WORD_W-1:0] pixel_value;
        logic              frame_done;
        logic              sync_lost;
        logic              frame_available;
        t_buf              taken_buffer;
    } t_result;

    // Next buffer in rotation, wrapping at the buffer count.
    function automatic t_buf buf_inc(t_buf from);
        t_buf b;
        if (from >= BUF_W'(BUFFER_COUNT - 1)) begin
            b = '0;
        end else begin
            b = from + 1'b1;
        end
        return b;
    endfunction

    // Next fill buffer after the given one, skipping the consumer's buffer.
    function automatic t_buf next_fill(t_buf from, t_buf consumer);
        t_buf b;
        b = buf_inc(from);
        if (b == consumer) begin
            b = buf_inc(b);
        end
        return b;
    endfunction

endpackage

// ===== sv/tvpr_if.sv =====
// Input channel: one command and link word per transfer.
interface tvpr_in_if;
    logic                        valid;
    logic                        ready;
    logic [tvpr_pkg::CMD_W-1:0]  cmd;
    logic [tvpr_pkg::WORD_W-1:0] link_word;

    modport source (output valid, output cmd, output link_word, input ready);
    modport sink   (input valid, input cmd, input link_word, output ready);
endinterface

// Output channel: one result per transfer.
interface tvpr_out_if;
    logic                        valid;
    logic                        ready;
    logic                        pixel_write;
    tvpr_pkg::t_buf              pixel_buffer;
    logic [tvpr_pkg::OFS_W-1:0]  pixel_offset;
    logic [tvpr_pkg::WORD_W-1:0] pixel_value;
    logic                        frame_done;
    logic                        sync_lost;
    logic                        frame_available;
    tvpr_pkg::t_buf              taken_buffer;

    modport source (
        output valid, output pixel_write, output pixel_buffer, output pixel_offset,
        output pixel_value, output frame_done, output sync_lost,
        output frame_available, output taken_buffer, input ready
    );
    modport sink (
        input valid, input pixel_write, input pixel_buffer, input pixel_offset,
        input pixel_value, input frame_done, input sync_lost,
        input frame_available, input taken_buffer, output ready
    );
endinterface

// ===== sv/tvpr_in_reg.sv =====
module tvpr_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tvpr_in_if.sink            i_in,
    input  logic               i_take,
    output logic               o_valid,
    output tvpr_pkg::t_in_item o_item
);

    logic               r_valid;
    tvpr_pkg::t_in_item r_item;

    // The register may refill whenever it is empty or its item moves on this cycle,
    // but never while reset is held.
    assign i_in.ready = i_rst_n && (!r_valid || i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Payload is captured on every input transfer.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.cmd       <= i_in.cmd;
            r_item.link_word <= i_in.link_word;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/tvpr_core.sv =====
module tvpr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_seg_mode,
    input  logic               i_step,
    input  tvpr_pkg::t_in_item i_item,
    output tvpr_pkg::t_result  o_result
);

    logic [tvpr_pkg::INDEX_W-1:0] r_word_index, n_word_index;
    logic [tvpr_pkg::PKT_W-1:0]   r_exp_pkt, n_exp_pkt;
    logic [tvpr_pkg::SEG_W-1:0]   r_exp_seg, n_exp_seg;
    logic                         r_pkt_acc, n_pkt_acc;
    logic                         r_await, n_await;
    tvpr_pkg::t_buf               r_fill, n_fill;
    tvpr_pkg::t_buf               r_newest, n_newest;
    tvpr_pkg::t_buf               r_consumer, n_consumer;

    logic [tvpr_pkg::PID_W-1:0]   pid;
    logic [tvpr_pkg::SEGF_W-1:0]  seg_field;
    logic [tvpr_pkg::SEGF_W-1:0]  seg_next;
    logic                         dont_care;
    logic                         mark;
    logic                         lost;
    logic                         frame;
    logic [tvpr_pkg::SUM_W-1:0]   ofs_sum;
    tvpr_pkg::t_result            res;

    // Header word decode.
    assign pid       = tvpr_pkg::PID_W'(i_item.link_word & tvpr_pkg::PACKET_NUM_MASK);
    assign seg_field = tvpr_pkg::SEGF_W'(i_item.link_word >> tvpr_pkg::SEG_FIELD_LSB)
                       & tvpr_pkg::SEG_FIELD_MASK;
    assign seg_next  = tvpr_pkg::SEGF_W'(r_exp_seg) + 1'b1;
    assign dont_care = (i_item.link_word & tvpr_pkg::DONT_CARE_MASK)
                       == tvpr_pkg::DONT_CARE_MASK;
    assign mark      = i_seg_mode
                       && (pid == tvpr_pkg::PID_W'(tvpr_pkg::SEGMENT_MARK_PACKET));

    // Pixel position within the frame, from the expected segment and packet.
    assign ofs_sum = tvpr_pkg::SUM_W'(r_exp_seg) * tvpr_pkg::SUM_W'(tvpr_pkg::SEGMENT_PIXELS)
                   + tvpr_pkg::SUM_W'(r_exp_pkt) * tvpr_pkg::SUM_W'(tvpr_pkg::PIXELS_PER_PACKET)
                   + tvpr_pkg::SUM_W'(r_word_index)
                   - tvpr_pkg::SUM_W'(tvpr_pkg::HEADER_WORDS);

    // Next state and result for the item at the head of the input register.
    always_comb begin
        n_word_index = r_word_index;
        n_exp_pkt    = r_exp_pkt;
        n_exp_seg    = r_exp_seg;
        n_pkt_acc    = r_pkt_acc;
        n_await      = r_await;
        n_fill       = r_fill;
        n_newest     = r_newest;
        n_consumer   = r_consumer;
        lost         = 1'b0;
        frame        = 1'b0;
        res          = '0;

        unique case (i_item.cmd)
            tvpr_pkg::CMD_RESYNC: begin
                n_await      = 1'b0;
                n_word_index = '0;
                n_pkt_acc    = 1'b0;
                n_fill       = tvpr_pkg::next_fill(r_newest, r_consumer);
            end
            tvpr_pkg::CMD_TAKE: begin
                n_consumer = r_newest;
            end
            tvpr_pkg::CMD_WORD: begin
                if (!r_await) begin
                    // The first header word decides whether the packet is kept.
                    if (r_word_index == '0) begin
                        n_pkt_acc = 1'b0;
                        priority if (dont_care) begin
                            n_pkt_acc = 1'b0;
                        end else if ((r_exp_pkt == '0) && (pid != '0)) begin
                            n_pkt_acc = 1'b0;
                        end else if (mark && (r_exp_seg == '0)
                                     && (seg_field != tvpr_pkg::SEGF_W'(1))) begin
                            n_exp_pkt = '0;
                        end else if ((pid != tvpr_pkg::PID_W'(r_exp_pkt))
                                     || (mark && (seg_field != seg_next))) begin
                            lost = 1'b1;
                        end else begin
                            n_pkt_acc = 1'b1;
                        end
                    end

                    if (lost) begin
                        n_exp_pkt    = '0;
                        n_exp_seg    = '0;
                        n_await      = 1'b1;
                        n_word_index = '0;
                    end else begin
                        if ((r_word_index >= tvpr_pkg::INDEX_W'(tvpr_pkg::HEADER_WORDS))
                            && n_pkt_acc) begin
                            res.pixel_write  = 1'b1;
                            res.pixel_buffer = r_fill;
                            res.pixel_offset = ofs_sum[tvpr_pkg::OFS_W-1:0];
                            res.pixel_value  = i_item.link_word;
                        end
                        // End of packet: advance the packet, segment and frame counts.
                        if (r_word_index >= tvpr_pkg::INDEX_W'(tvpr_pkg::PACKET_WORDS - 1)) begin
                            n_word_index = '0;
                            if (n_pkt_acc) begin
                                if (r_exp_pkt >=
                                    tvpr_pkg::PKT_W'(tvpr_pkg::PACKETS_PER_SEGMENT - 1)) begin
                                    n_exp_pkt = '0;
                                    if (i_seg_mode) begin
                                        if (r_exp_seg >= tvpr_pkg::SEG_W'(
                                                tvpr_pkg::SEGMENTS_PER_FRAME - 1)) begin
                                            n_exp_seg = '0;
                                            frame     = 1'b1;
                                        end else begin
                                            n_exp_seg = r_exp_seg + 1'b1;
                                        end
                                    end else begin
                                        frame = 1'b1;
                                    end
                                end else begin
                                    n_exp_pkt = r_exp_pkt + 1'b1;
                                end
                                if (frame) begin
                                    n_newest = r_fill;
                                    n_fill   = tvpr_pkg::next_fill(r_fill, r_consumer);
                                end
                            end
                            n_pkt_acc = 1'b0;
                        end else begin
                            n_word_index = r_word_index + 1'b1;
                        end
                    end
                end
            end
            tvpr_pkg::CMD_NOP: begin
                n_pkt_acc = r_pkt_acc;
            end
        endcase

        res.frame_done      = frame;
        res.sync_lost       = lost;
        res.frame_available = n_newest != n_consumer;
        res.taken_buffer    = n_consumer;
    end

    assign o_result = res;

    // Receiver state advances once per item that moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_index <= '0;
            r_exp_pkt    <= '0;
            r_exp_seg    <= '0;
            r_pkt_acc    <= 1'b0;
            r_await      <= 1'b1;
            r_fill       <= tvpr_pkg::t_buf'(1);
            r_newest     <= '0;
            r_consumer   <= '0;
        end else if (i_step) begin
            r_word_index <= n_word_index;
            r_exp_pkt    <= n_exp_pkt;
            r_exp_seg    <= n_exp_seg;
            r_pkt_acc    <= n_pkt_acc;
            r_await      <= n_await;
            r_fill       <= n_fill;
            r_newest     <= n_newest;
            r_consumer   <= n_consumer;
        end
    end

endmodule

// ===== sv/tvpr_out_reg.sv =====
module tvpr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tvpr_pkg::t_result i_result,
    output logic              o_can_load,
    tvpr_out_if.source        o_out
);

    logic              r_valid;
    tvpr_pkg::t_result r_result;

    // A new result may enter when the register is empty or being emptied.
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.pixel_write     = r_result.pixel_write;
    assign o_out.pixel_buffer    = r_result.pixel_buffer;
    assign o_out.pixel_offset    = r_result.pixel_offset;
    assign o_out.pixel_value     = r_result.pixel_value;
    assign o_out.frame_done      = r_result.frame_done;
    assign o_out.sync_lost       = r_result.sync_lost;
    assign o_out.frame_available = r_result.frame_available;
    assign o_out.taken_buffer    = r_result.taken_buffer;

endmodule

// ===== sv/thermal_video_packet_receiver_unit.sv =====
// Channel    Direction  Transfer carries
// i_in       sink       cmd, link_word
// o_out      source     pixel_write, pixel_buffer, pixel_offset, pixel_value,
//                       frame_done, sync_lost, frame_available, taken_buffer
// i_cfg_*    write      segmented_mode
//
// One item per cycle sustained while results are taken; each result passes from the input
// register through single-pass deframing logic into the result register.
// Reset is synchronous and active low; input ready is held low during it, and with no
// clearing pass the block takes items from the first cycle after reset.
// Outside reset, input ready drops only while the input register holds an item and the
// result register is full and not being taken.
module thermal_video_packet_receiver_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    tvpr_in_if.sink    i_in,
    tvpr_out_if.source o_out
);

    logic               r_seg_mode;
    logic               in_valid;
    tvpr_pkg::t_in_item in_item;
    logic               can_load;
    logic               step;
    tvpr_pkg::t_result  result;

    // Segmented mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_seg_mode <= i_cfg_data;
        end
    end

    assign step = in_valid && can_load;

    tvpr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (step),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    tvpr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seg_mode (r_seg_mode),
        .i_step     (step),
        .i_item     (in_item),
        .o_result   (result)
    );

    tvpr_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (result),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    // A completed frame always ends on a stored pixel.
    a_done_has_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_done) |-> o_out.pixel_write)
        else $error("frame_done without pixel_write");

    // A header that breaks sync stores nothing and completes nothing.
    a_lost_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.sync_lost) |-> (!o_out.pixel_write && !o_out.frame_done))
        else $error("sync_lost together with pixel or frame");

    // Pixels never land in the buffer the consumer owns.
    a_fill_not_consumer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.pixel_write) |-> (o_out.pixel_buffer != o_out.taken_buffer))
        else $error("pixel written into consumer buffer");

    // Pixel offsets stay inside one frame.
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.pixel_write)
        |-> (o_out.pixel_offset < tvpr_pkg::OFS_W'(tvpr_pkg::FRAME_PIXELS)))
        else $error("pixel offset beyond frame");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import tvpr_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;

    // One row of the directed stimulus; res is only used when typed is set.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] word;
        logic              typed;
        t_result           res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;

    tvpr_in_if  in_ch ();
    tvpr_out_if out_ch ();

    thermal_video_packet_receiver_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Deframer state as predicted by the testbench.
    logic [6:0]        rx_pos;
    logic [5:0]        rx_expect_pkt;
    logic [SEG_W-1:0]  rx_expect_seg;
    logic              rx_pkt_open;
    logic              rx_wait_sync;
    t_buf              rx_fill;
    t_buf              rx_newest;
    t_buf              rx_consumer;
    logic              rx_seg_mode;

    t_result   pending_results [$];
    t_stim_row directed_rows [24];

    int   error_count    = 0;
    int   report_count   = 0;
    int   checked_count  = 0;
    int   transfer_count = 0;
    int   pixel_count    = 0;
    int   frame_count    = 0;
    int   lost_count     = 0;
    int   cycle_count    = 0;
    int   hold_requests;
    logic calm;

    // Free-running clock, period 10.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Buffer after the given one, stepping over the buffer the consumer holds.
    function automatic t_buf rotate_past(input t_buf from);
        int b;
        b = (int'(from) + 1) % BUFFER_COUNT;
        if (b == int'(rx_consumer)) begin
            b = (b + 1) % BUFFER_COUNT;
        end
        return t_buf'(b);
    endfunction

    // Advances the predicted deframer by one input item and returns its result.
    function automatic t_result deframe_word(input logic [CMD_W-1:0] cmd,
                                             input logic [WORD_W-1:0] word);
        t_result           r;
        logic [PID_W-1:0]  pid;
        logic [SEGF_W-1:0] segf;
        logic              marker;
        logic              lost;
        logic              frame;
        int                pos;
        int                ofs;
        r      = '0;
        lost   = 1'b0;
        frame  = 1'b0;
        pid    = PID_W'(word & PACKET_NUM_MASK);
        segf   = SEGF_W'(word >> SEG_FIELD_LSB) & SEG_FIELD_MASK;
        marker = rx_seg_mode && (pid == PID_W'(SEGMENT_MARK_PACKET));
        pos    = int'(rx_pos);
        if (cmd == CMD_RESYNC) begin
            rx_wait_sync = 1'b0;
            rx_pos       = '0;
            rx_pkt_open  = 1'b0;
            rx_fill      = rotate_past(rx_newest);
        end else if (cmd == CMD_TAKE) begin
            rx_consumer = rx_newest;
        end else if (cmd == CMD_WORD && !rx_wait_sync) begin
            // Header word: take the packet, skip it, or drop sync.
            if (pos == 0) begin
                rx_pkt_open = 1'b0;
                // Don't-care packets and anything before packet zero are skipped.
                if ((word & DONT_CARE_MASK) != DONT_CARE_MASK &&
                    (rx_expect_pkt != 0 || pid == 0)) begin
                    if (marker && rx_expect_seg == 0 && segf != 1) begin
                        rx_expect_pkt = '0;
                    end else if (pid != PID_W'(rx_expect_pkt) ||
                                 (marker && int'(segf) != int'(rx_expect_seg) + 1)) begin
                        rx_expect_pkt = '0;
                        rx_expect_seg = '0;
                        rx_wait_sync  = 1'b1;
                        lost          = 1'b1;
                    end else begin
                        rx_pkt_open = 1'b1;
                    end
                end
            end
            if (lost) begin
                rx_pos = '0;
            end else begin
                if (pos >= HEADER_WORDS && rx_pkt_open) begin
                    ofs = int'(rx_expect_seg) * SEGMENT_PIXELS
                        + int'(rx_expect_pkt) * PIXELS_PER_PACKET + pos - HEADER_WORDS;
                    r.pixel_write  = 1'b1;
                    r.pixel_buffer = rx_fill;
                    r.pixel_offset = OFS_W'(ofs);
                    r.pixel_value  = word;
                end
                // Last word of the packet: move on to the next packet, maybe a new frame.
                if (pos + 1 >= PACKET_WORDS) begin
                    rx_pos = '0;
                    if (rx_pkt_open) begin
                        if (int'(rx_expect_pkt) + 1 >= PACKETS_PER_SEGMENT) begin
                            rx_expect_pkt = '0;
                            if (!rx_seg_mode) begin
                                frame = 1'b1;
                            end else if (int'(rx_expect_seg) + 1 >= SEGMENTS_PER_FRAME) begin
                                rx_expect_seg = '0;
                                frame         = 1'b1;
                            end else begin
                                rx_expect_seg = rx_expect_seg + 1'b1;
                            end
                        end else begin
                            rx_expect_pkt = rx_expect_pkt + 1'b1;
                        end
                        if (frame) begin
                            rx_newest = rx_fill;
                            rx_fill   = rotate_past(rx_fill);
                        end
                    end
                    rx_pkt_open = 1'b0;
                end else begin
                    rx_pos = 7'(pos + 1);
                end
            end
        end
        r.frame_done      = frame;
        r.sync_lost       = lost;
        r.frame_available = (rx_newest != rx_consumer);
        r.taken_buffer    = rx_consumer;
        return r;
    endfunction

    // Offers one item, waits for the transfer and queues what it should produce.
    task automatic transfer_item(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word,
                                 input logic typed, input t_result typed_res);
        t_result predicted;
        while (!calm && $urandom_range(99) < 6) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.link_word <= word;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        predicted = deframe_word(cmd, word);
        pending_results.push_back(typed ? typed_res : predicted);
        transfer_count++;
    endtask

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word);
        transfer_item(cmd, word, 1'b0, '0);
    endtask

    // A header followed by random words, count words in all.
    task automatic send_packet(input logic [WORD_W-1:0] hdr, input int count);
        send_word(CMD_WORD, hdr);
        for (int i = 1; i < count; i++) begin
            send_word(CMD_WORD, WORD_W'($urandom));
        end
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rx_seg_mode = mode;
    endtask

    // Random traffic of about the given number of items: mostly in-order packets, with
    // noise in per-mille per action. The calm stretch and the hold-off point are counted
    // in items sent during the phase.
    task automatic run_phase(input logic mode, input int items, input int noise,
                             input int calm_items, input int hold_at);
        int                first_item;
        int                sent;
        int                roll;
        logic [SEGF_W-1:0] segf;
        logic [PID_W-1:0]  pid;
        logic [WORD_W-1:0] hdr;
        write_mode(mode);
        first_item = transfer_count;
        sent       = 0;
        calm <= (calm_items > 0);
        while (sent < items) begin
            if (calm_items > 0 && sent >= calm_items) begin
                calm <= 1'b0;
                calm_items = -1;
            end
            if (hold_at >= 0 && sent >= hold_at) begin
                hold_requests <= hold_requests + 1;
                hold_at = -1;
            end
            if (rx_wait_sync) begin
                // Lost sync: mostly resync, some commands, some words that are dropped.
                roll = $urandom_range(99);
                if (roll < 60) begin
                    send_word(CMD_RESYNC, WORD_W'($urandom));
                end else if (roll < 70) begin
                    send_word(CMD_TAKE, WORD_W'($urandom));
                end else if (roll < 75) begin
                    send_word(CMD_NOP, WORD_W'($urandom));
                end else begin
                    send_word(CMD_WORD, WORD_W'($urandom));
                end
            end else begin
                // Header of the packet the block is waiting for.
                segf = SEGF_W'($urandom_range(7));
                if (rx_seg_mode && rx_expect_pkt == SEGMENT_MARK_PACKET) begin
                    segf = SEGF_W'(rx_expect_seg + 1);
                end
                hdr  = {1'($urandom_range(1)), segf, PID_W'(rx_expect_pkt)};
                roll = $urandom_range(999);
                if (roll < noise) begin
                    case ($urandom_range(3))
                        0: begin
                            pid = PID_W'((int'(rx_expect_pkt)
                                  + $urandom_range(1, PACKETS_PER_SEGMENT - 1))
                                  % PACKETS_PER_SEGMENT);
                            send_packet({1'($urandom_range(1)), SEGF_W'($urandom_range(7)), pid},
                                        PACKET_WORDS);
                        end
                        1: begin
                            do begin
                                segf = SEGF_W'($urandom_range(7));
                            end while (int'(segf) == int'(rx_expect_seg) + 1);
                            send_packet({1'($urandom_range(1)), segf,
                                         PID_W'(SEGMENT_MARK_PACKET)}, PACKET_WORDS);
                        end
                        2: send_packet(hdr, $urandom_range(1, PACKET_WORDS - 1));
                        default: begin
                            repeat ($urandom_range(1, 3)) send_word(CMD_WORD, WORD_W'($urandom));
                        end
                    endcase
                end else if (roll < noise + 30) begin
                    send_word(CMD_TAKE, WORD_W'($urandom));
                end else if (roll < noise + 45) begin
                    send_word(CMD_NOP, WORD_W'($urandom));
                end else if (roll < noise + 55) begin
                    send_word(CMD_RESYNC, WORD_W'($urandom));
                end else if (roll < noise + 85) begin
                    send_packet(WORD_W'($urandom) | DONT_CARE_MASK, PACKET_WORDS);
                end else begin
                    // Realign after a short packet now and then, as a host would.
                    if (rx_pos != 0 && $urandom_range(1) == 1) begin
                        send_word(CMD_RESYNC, WORD_W'($urandom));
                    end
                    send_packet(hdr, PACKET_WORDS);
                end
            end
            sent = transfer_count - first_item;
        end
    endtask

    // Consumer side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 6);
            end
        end
    end

    // Compare every result transfer with the oldest pending prediction.
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.pixel_write     = out_ch.pixel_write;
            got.pixel_buffer    = out_ch.pixel_buffer;
            got.pixel_offset    = out_ch.pixel_offset;
            got.pixel_value     = out_ch.pixel_value;
            got.frame_done      = out_ch.frame_done;
            got.sync_lost       = out_ch.sync_lost;
            got.frame_available = out_ch.frame_available;
            got.taken_buffer    = out_ch.taken_buffer;
            if (pending_results.size() == 0) begin
                error_count++;
                if (report_count < MAX_REPORTS) begin
                    $display("Result with nothing pending: wr=%0d buf=%0d ofs=%0d val=%h",
                             got.pixel_write, got.pixel_buffer, got.pixel_offset,
                             got.pixel_value);
                end
                report_count++;
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                pixel_count += int'(want.pixel_write);
                frame_count += int'(want.frame_done);
                lost_count  += int'(want.sync_lost);
                if (got.pixel_write !== want.pixel_write ||
                    got.pixel_buffer !== want.pixel_buffer ||
                    got.pixel_offset !== want.pixel_offset ||
                    got.pixel_value !== want.pixel_value ||
                    got.frame_done !== want.frame_done ||
                    got.sync_lost !== want.sync_lost ||
                    got.frame_available !== want.frame_available ||
                    got.taken_buffer !== want.taken_buffer) begin
                    error_count++;
                    if (report_count < MAX_REPORTS) begin
                        $display("Mismatch on result %0d: expected wr=%0d buf=%0d ofs=%0d %s",
                                 checked_count, want.pixel_write, want.pixel_buffer,
                                 want.pixel_offset, "(see fields below)");
                        $display("  expected val=%h done=%0d lost=%0d avail=%0d taken=%0d",
                                 want.pixel_value, want.frame_done, want.sync_lost,
                                 want.frame_available, want.taken_buffer);
                        $display("  got wr=%0d buf=%0d ofs=%0d val=%h done=%0d lost=%0d %s%0d %s%0d",
                                 got.pixel_write, got.pixel_buffer, got.pixel_offset,
                                 got.pixel_value, got.frame_done, got.sync_lost,
                                 "avail=", got.frame_available, "taken=", got.taken_buffer);
                    end
                    report_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Reset, directed rows, then random phases in both framing modes.
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_NOP;
        in_ch.link_word = '0;
        calm            = 1'b0;
        hold_requests   = 0;
        rx_pos          = '0;
        rx_expect_pkt   = '0;
        rx_expect_seg   = '0;
        rx_pkt_open     = 1'b0;
        rx_wait_sync    = 1'b1;
        rx_fill         = t_buf'(1);
        rx_newest       = '0;
        rx_consumer     = '0;
        rx_seg_mode     = 1'b0;

        directed_rows = '{
            // Dropped while waiting for resync, link word extremes, no-op and empty take.
            '{CMD_WORD,   16'h0000, 1'b1, '0},
            '{CMD_WORD,   16'hFFFF, 1'b1, '0},
            '{CMD_NOP,    16'hFFFF, 1'b1, '0},
            '{CMD_TAKE,   16'h0000, 1'b1, '0},
            '{CMD_RESYNC, 16'h0000, 1'b1, '0},
            // Don't-care packet, then a packet ahead of packet zero.
            '{CMD_WORD,   16'h0F00, 1'b1, '0},
            '{CMD_WORD,   16'h1234, 1'b1, '0},
            '{CMD_RESYNC, 16'hFFFF, 1'b1, '0},
            '{CMD_WORD,   16'h0005, 1'b1, '0},
            '{CMD_RESYNC, 16'h0000, 1'b1, '0},
            // Packet zero with a set top bit, its second header word and extreme pixels.
            '{CMD_WORD,   16'hF000, 1'b1, '0},
            '{CMD_WORD,   16'hABCD, 1'b1, '0},
            '{CMD_WORD,   16'h0000, 1'b1,
              '{1'b1, 2'd1, 15'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 2'd0}},
            '{CMD_WORD,   16'hFFFF, 1'b1,
              '{1'b1, 2'd1, 15'd1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 2'd0}},
            '{CMD_WORD,   16'h8001, 1'b0, '0},
            '{CMD_TAKE,   16'hFFFF, 1'b0, '0},
            '{CMD_NOP,    16'h5A5A, 1'b0, '0},
            '{CMD_WORD,   16'h7FFE, 1'b0, '0},
            // Resync in the middle of a packet restarts the framing.
            '{CMD_RESYNC, 16'hFFFF, 1'b0, '0},
            '{CMD_WORD,   16'h0FFF, 1'b1, '0},
            '{CMD_RESYNC, 16'h0000, 1'b1, '0},
            '{CMD_WORD,   16'h7000, 1'b0, '0},
            '{CMD_WORD,   16'h0000, 1'b0, '0},
            '{CMD_WORD,   16'h1111, 1'b0, '0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            transfer_item(directed_rows[i].cmd, directed_rows[i].word,
                          directed_rows[i].typed, directed_rows[i].res);
        end

        run_phase(1'b0, 370, 5, 0, 120);
        run_phase(1'b1, 370, 2, 200, -1);
        run_phase(1'b0, 370, 60, 0, -1);
        run_phase(1'b1, 370, 10, 0, 250);
        drain_results();

        $display("Checked %0d results for %0d transfers: %0d pixel writes, %0d frames, %s%0d.",
                 checked_count, transfer_count, pixel_count, frame_count,
                 "sync losses ", lost_count);
        $display("Both framing modes ran with random stalls on each side and consumer hold-offs.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tvpr_pkg.sv
sv/tvpr_if.sv
sv/tvpr_in_reg.sv
sv/tvpr_core.sv
sv/tvpr_out_reg.sv
sv/thermal_video_packet_receiver_unit.sv
tb/sv/testbench.sv
